### rtl/arpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types and constants of the arp cache and responder
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int TableDepth = 128;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int CntW       = $clog2(TableDepth + 1);
    // entry word: ip 32, mac 48, protocol 16, age 8
    localparam int EntryW     = 104;

    localparam logic [1:0] MODE_RX   = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_LOOK = 2'd2;
    localparam logic [1:0] MODE_REQ  = 2'd3;

    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_REPLY  = 3'd1;
    localparam logic [2:0] ST_BAD_HW = 3'd2;
    localparam logic [2:0] ST_BAD_PR = 3'd3;
    localparam logic [2:0] ST_HIT    = 3'd4;
    localparam logic [2:0] ST_MISS   = 3'd5;
    localparam logic [2:0] ST_REQ    = 3'd6;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OP_REQUEST  = 16'h0001;
    localparam logic [15:0] OP_REPLY    = 16'h0002;
    localparam logic [47:0] MAC_BCAST   = 48'hffff_ffff_ffff;

    localparam logic [0:0] ADDR_OWN_IP  = 1'b0;
    localparam logic [0:0] ADDR_OWN_MAC = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [15:0] operation;
        logic [31:0] snd_ip;
        logic [47:0] snd_mac;
        logic [31:0] tgt_ip;
        logic [47:0] frame_source_mac;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] send_dest_mac;
        logic [15:0] send_operation;
        logic [47:0] send_target_mac;
        logic [31:0] send_target_ip;
        logic [47:0] found_mac;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic            load;      // capture input item
        logic            clr_wr;    // clearing pass write
        logic            rd;        // issue table read at idx
        logic            scan_rst;  // reset scan bookkeeping
        logic            look;      // examine read data (find/insert scan)
        logic            age_wr;    // write back aged entry
        logic            merge_wr;  // write merged mac at hit
        logic            ins_wr;    // write insert at pick
        logic            done;      // build result
        logic [IdxW-1:0] idx;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       hw_ok;
        logic       pr_ok;
        logic       hit;
        logic       merge;
        logic       to_us;
    } stat_t;

endpackage

### rtl/arpc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### rtl/arpc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_datapath
// item register, table ram, scan compare and result build
// ----------------------------------------------------------------------------
module arpc_datapath (
    input  logic                aclk,
    input  arpc_pkg::item_t     item_in,
    input  logic [31:0]         own_ip,
    input  arpc_pkg::cmd_t      cmd,
    output arpc_pkg::stat_t     stat,
    output arpc_pkg::result_t   result
);
    import arpc_pkg::*;

    item_t            item_reg;
    logic [EntryW-1:0] rdata, wdata;
    logic              we;
    logic [IdxW-1:0]   addr;
    logic [IdxW-1:0]   rd_idx_reg;
    logic              hit_reg, free_reg;
    logic [IdxW-1:0]   hit_idx_reg, pick_reg;
    logic [7:0]        best_reg;
    logic [47:0]       hit_mac_reg;
    logic [7:0]        hit_age_reg;
    logic              merge_reg;
    result_t           result_reg, result_next;

    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic [15:0] r_pr;
    logic [7:0]  r_age;
    logic [31:0] key;

    assign {r_ip, r_mac, r_pr, r_age} = rdata;
    assign key = (item_reg.mode == MODE_LOOK) ? item_reg.tgt_ip : item_reg.snd_ip;

    always_comb begin
        we    = 1'b0;
        addr  = cmd.idx;
        wdata = '0;
        if (cmd.clr_wr) begin
            we = 1'b1;
        end else if (cmd.age_wr) begin
            we    = 1'b1;
            addr  = rd_idx_reg;
            wdata = {r_ip, r_mac, r_pr, (r_ip != 32'd0) ? r_age + 8'd1 : r_age};
        end else if (cmd.merge_wr) begin
            // hit entry holds the sender ip and the same protocol
            we    = 1'b1;
            addr  = hit_idx_reg;
            wdata = {item_reg.snd_ip, item_reg.snd_mac, item_reg.proto_type, hit_age_reg};
        end else if (cmd.ins_wr) begin
            we    = 1'b1;
            addr  = pick_reg;
            wdata = {item_reg.snd_ip, item_reg.snd_mac, item_reg.proto_type, 8'd0};
        end
    end

    arpc_ram #(.Width(EntryW), .Depth(TableDepth)) u_tbl (
        .aclk (aclk),
        .we   (we),
        .addr (addr),
        .wdata(wdata),
        .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= item_in;
        end
        if (cmd.rd) begin
            rd_idx_reg <= cmd.idx;
        end
        if (cmd.scan_rst) begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            best_reg <= 8'd0;
            pick_reg <= '0;
        end else if (cmd.look) begin
            if (!hit_reg && r_ip == key) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= rd_idx_reg;
                hit_mac_reg <= r_mac;
                hit_age_reg <= r_age;
                merge_reg   <= (r_pr == item_reg.proto_type);
            end
            if (!free_reg) begin
                if (r_ip == 32'd0) begin
                    free_reg <= 1'b1;
                    pick_reg <= rd_idx_reg;
                end else if (r_age >= best_reg) begin
                    best_reg <= r_age;
                    pick_reg <= rd_idx_reg;
                end
            end
        end
        if (cmd.done) begin
            result_reg <= result_next;
        end
    end

    always_comb begin
        result_next = '0;
        unique case (item_reg.mode)
            MODE_RX: begin
                if (item_reg.hw_type != HW_ETHERNET) begin
                    result_next.status = ST_BAD_HW;
                end else if (item_reg.proto_type != PROTO_IPV4) begin
                    result_next.status = ST_BAD_PR;
                end else if (item_reg.tgt_ip == own_ip
                             && item_reg.operation == OP_REQUEST) begin
                    result_next.status          = ST_REPLY;
                    result_next.send_dest_mac   = item_reg.frame_source_mac;
                    result_next.send_operation  = OP_REPLY;
                    result_next.send_target_mac = item_reg.snd_mac;
                    result_next.send_target_ip  = item_reg.snd_ip;
                end
            end
            MODE_TICK: result_next.status = ST_DONE;
            MODE_LOOK: begin
                if (hit_reg) begin
                    result_next.status    = ST_HIT;
                    result_next.found_mac = hit_mac_reg;
                end else begin
                    result_next.status = ST_MISS;
                end
            end
            default: begin
                result_next.status          = ST_REQ;
                result_next.send_dest_mac   = MAC_BCAST;
                result_next.send_operation  = OP_REQUEST;
                result_next.send_target_mac = MAC_BCAST;
                result_next.send_target_ip  = item_reg.tgt_ip;
            end
        endcase
    end

    assign stat.mode  = item_reg.mode;
    assign stat.hw_ok = item_reg.hw_type == HW_ETHERNET;
    assign stat.pr_ok = item_reg.proto_type == PROTO_IPV4;
    assign stat.hit   = hit_reg;
    assign stat.merge = hit_reg && merge_reg;
    assign stat.to_us = item_reg.tgt_ip == own_ip;
    assign result     = result_reg;
endmodule

### rtl/arpc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ctrl
// sequencer for clearing, scans, table writes and result handoff
// ----------------------------------------------------------------------------
module arpc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_fire,
    input  logic            m_free,
    input  arpc_pkg::stat_t stat,
    output arpc_pkg::cmd_t  cmd,
    output logic            idle,
    output logic            out_load
);
    import arpc_pkg::*;

    typedef enum logic [7:0] {
        S_CLR   = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DISP  = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_LAST  = 8'b0001_0000,
        S_MRD   = 8'b0010_0000,
        S_WR    = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.idx    = cnt_reg[IdxW-1:0];
        idle       = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_CLR: begin
                cmd.clr_wr = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(TableDepth - 1)) begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                idle     = 1'b1;
                cmd.load = s_fire;
                if (s_fire) begin
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                cmd.scan_rst = 1'b1;
                cnt_next     = '0;
                if (stat.mode == MODE_REQ
                    || (stat.mode == MODE_RX && !(stat.hw_ok && stat.pr_ok))) begin
                    state_next = S_OUT;
                end else begin
                    cmd.rd     = 1'b1;
                    cmd.idx    = '0;
                    cnt_next   = CntW'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // data of entry cnt-1 is on the ram output
                if (stat.mode == MODE_TICK) begin
                    cmd.age_wr = 1'b1;
                end else begin
                    cmd.look = 1'b1;
                end
                if (cnt_reg == CntW'(TableDepth)) begin
                    state_next = S_LAST;
                end else if (stat.mode == MODE_TICK) begin
                    state_next = S_MRD;
                end else begin
                    cmd.rd   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MRD: begin
                // age writes share the port: reread after each write
                cmd.rd     = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_SCAN;
            end
            S_LAST: begin
                state_next = S_OUT;
                if (stat.mode == MODE_RX) begin
                    state_next = S_WR;
                end
            end
            S_WR: begin
                if (stat.merge) begin
                    cmd.merge_wr = 1'b1;
                end else if (stat.to_us) begin
                    cmd.ins_wr = 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_free) begin
                    cmd.done   = 1'b1;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLR;
        endcase
    end
endmodule

### rtl/arp_cache_and_responder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_and_responder_top
// arp translation table with reply and request engine
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | one item: mode, arp header fields, frame source
//  m_axis    | out       | one result per item: status, send fields, found mac
//  apb       | in/out    | own_ip at 0x0, own_mac at 0x8
//
// after reset a clearing pass writes all 128 entries, no items taken
// lookup and packet: one read scan of the table
// aging tick: read then write per entry over the single ram port
// bad header and send request: no table access
// one item at a time; the result waits in the output register until taken
// ----------------------------------------------------------------------------
module arp_cache_and_responder_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode, hw_type, proto_type, operation, snd_ip, snd_mac, tgt_ip,
    // frame_source_mac (lowest first), zero filled to 216 bits
    input  logic [215:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, send_dest_mac, send_operation, send_target_mac,
    // send_target_ip, found_mac (lowest first), zero filled to 200 bits
    output logic [199:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import arpc_pkg::*;

    item_t   item_in;
    cmd_t    cmd;
    stat_t   stat;
    result_t result;
    logic    idle, out_load, s_fire;
    logic    m_valid_reg;
    logic [31:0] own_ip_reg;
    logic [47:0] own_mac_reg;

    // field unpack, first field lowest
    assign item_in.mode             = s_tdata[1:0];
    assign item_in.hw_type          = s_tdata[17:2];
    assign item_in.proto_type       = s_tdata[33:18];
    assign item_in.operation        = s_tdata[49:34];
    assign item_in.snd_ip           = s_tdata[81:50];
    assign item_in.snd_mac          = s_tdata[129:82];
    assign item_in.tgt_ip           = s_tdata[161:130];
    assign item_in.frame_source_mac = s_tdata[209:162];

    assign s_tready = idle;
    assign s_fire   = s_tvalid && s_tready;

    // config registers, write in access phase
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[3] == ADDR_OWN_IP && paddr[2:0] == 3'd0) begin
                own_ip_reg <= pwdata[31:0];
            end else if (paddr[3] == ADDR_OWN_MAC && paddr[2:0] == 3'd0) begin
                own_mac_reg <= pwdata[47:0];
            end
        end
    end
    assign prdata = (paddr[3] == ADDR_OWN_MAC) ? {16'd0, own_mac_reg} : {32'd0, own_ip_reg};

    arpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_fire  (s_fire),
        .m_free  (!m_valid_reg || m_tready),
        .stat    (stat),
        .cmd     (cmd),
        .idle    (idle),
        .out_load(out_load)
    );

    arpc_datapath u_dp (
        .aclk   (aclk),
        .item_in(item_in),
        .own_ip (own_ip_reg),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

    // result appears in the cycle after out_load latches it in the datapath
    logic out_pend_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            out_pend_reg <= 1'b0;
        end else begin
            out_pend_reg <= out_load;
            if (out_pend_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, result.found_mac, result.send_target_ip, result.send_target_mac,
                       result.send_operation, result.send_dest_mac, result.status};

    // a stalled output word holds steady
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");
    // a new result is never latched over one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_pend_reg |-> !m_valid_reg)
        else $error("result overwrite");
    // one item in flight: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accept while busy");
endmodule
